FILE: design/msl_pkg.sv
// Package for the single-linkage clustering block: controller states, command
// and status structs, fixed field widths. No dependencies.
package msl_pkg;

    localparam int DistW  = 32;
    localparam int IdW    = 7;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_INIT,
        ST_PRIM_START,
        ST_PRIM_RD,
        ST_PRIM_WAIT,
        ST_PRIM_UPD,
        ST_PRIM_END,
        ST_SORT_START,
        ST_SORT_RD,
        ST_SORT_CMP,
        ST_SORT_WR,
        ST_SORT_NEXT,
        ST_UF_RD,
        ST_UF_WAIT,
        ST_UF_FIND,
        ST_UF_EMIT
    } msl_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load_wr;      // store an input distance
        logic load_clr;     // restart the load counter
        logic init_clr;     // clear tree flags, reach minima, parent links (sweep)
        logic prim_start;   // mark x in tree, reset candidate
        logic prim_rd;      // read distance (x, j)
        logic prim_upd;     // update reach and candidate for j
        logic prim_next_j;  // advance j
        logic prim_end;     // record edge i, x <= y, i++
        logic sort_start;   // begin insertion of edge i
        logic sort_rd;      // read edge k-1
        logic sort_shift;   // edge[k] <= edge[k-1], k--
        logic sort_place;   // edge[k] <= e, i++
        logic uf_rd;        // read edge i, start root walk
        logic uf_step;      // one walk step from the parent read
        logic uf_emit;      // write result, link roots, i++
        logic run_start;    // reset i counter
    } msl_cmd_t;

    // status back to controller
    typedef struct packed {
        logic load_done;    // last distance of the matrix stored
        logic init_done;    // clear sweep finished
        logic j_in_tree;    // current j already in tree
        logic j_last;       // j is last point
        logic i_last_prim;  // edge i is the last tree edge
        logic sort_done;    // insertion pass over all edges complete
        logic sort_move;    // edge k-1 is longer than the inserted edge
        logic k_zero;       // insertion point reached front
        logic roots_found;  // both root walks stopped
        logic out_busy;     // output register holds an item not yet taken
        logic run_last;     // the merge being emitted is the final one
    } msl_sts_t;

endpackage

FILE: design/msl_ctrl.sv
// Controller of the clustering block: sequences load, clear sweep, Prim's tree,
// stable insertion sort and union-find emission. Depends on msl_pkg.
module msl_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  msl_pkg::msl_sts_t   sts,
    output msl_pkg::msl_cmd_t   cmd,
    output logic                busy
);

    msl_pkg::msl_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= msl_pkg::ST_LOAD;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        busy       = 1'b1;
        unique case (state_reg)
            msl_pkg::ST_LOAD:
            begin
                in_ready = 1'b1;
                busy     = 1'b0;
                if (in_valid)
                begin
                    cmd.load_wr = 1'b1;
                    if (sts.load_done)
                    begin
                        cmd.load_clr = 1'b1;
                        state_next   = msl_pkg::ST_INIT;
                    end
                end
            end
            msl_pkg::ST_INIT:
            begin
                cmd.init_clr = 1'b1;
                if (sts.init_done)
                begin
                    cmd.run_start = 1'b1;
                    state_next    = msl_pkg::ST_PRIM_START;
                end
            end
            msl_pkg::ST_PRIM_START:
            begin
                cmd.prim_start = 1'b1;
                state_next     = msl_pkg::ST_PRIM_RD;
            end
            msl_pkg::ST_PRIM_RD:
            begin
                cmd.prim_rd = 1'b1;
                state_next  = msl_pkg::ST_PRIM_WAIT;
            end
            msl_pkg::ST_PRIM_WAIT:
            begin
                state_next = msl_pkg::ST_PRIM_UPD;
            end
            msl_pkg::ST_PRIM_UPD:
            begin
                if (!sts.j_in_tree)
                    cmd.prim_upd = 1'b1;
                if (sts.j_last)
                    state_next = msl_pkg::ST_PRIM_END;
                else
                begin
                    cmd.prim_next_j = 1'b1;
                    state_next      = msl_pkg::ST_PRIM_RD;
                end
            end
            msl_pkg::ST_PRIM_END:
            begin
                cmd.prim_end = 1'b1;
                if (sts.i_last_prim)
                    state_next = msl_pkg::ST_SORT_START;
                else
                    state_next = msl_pkg::ST_PRIM_START;
            end
            msl_pkg::ST_SORT_START:
            begin
                if (sts.sort_done)
                begin
                    cmd.run_start = 1'b1;
                    state_next    = msl_pkg::ST_UF_RD;
                end
                else
                begin
                    cmd.sort_start = 1'b1;
                    state_next     = msl_pkg::ST_SORT_RD;
                end
            end
            msl_pkg::ST_SORT_RD:
            begin
                if (sts.k_zero)
                    state_next = msl_pkg::ST_SORT_WR;
                else
                begin
                    cmd.sort_rd = 1'b1;
                    state_next  = msl_pkg::ST_SORT_CMP;
                end
            end
            msl_pkg::ST_SORT_CMP:
            begin
                if (sts.sort_move)
                begin
                    cmd.sort_shift = 1'b1;
                    state_next     = msl_pkg::ST_SORT_RD;
                end
                else
                    state_next = msl_pkg::ST_SORT_WR;
            end
            msl_pkg::ST_SORT_WR:
            begin
                cmd.sort_place = 1'b1;
                state_next     = msl_pkg::ST_SORT_NEXT;
            end
            msl_pkg::ST_SORT_NEXT:
            begin
                state_next = msl_pkg::ST_SORT_START;
            end
            msl_pkg::ST_UF_RD:
            begin
                cmd.uf_rd  = 1'b1;
                state_next = msl_pkg::ST_UF_WAIT;
            end
            msl_pkg::ST_UF_WAIT:
            begin
                state_next = msl_pkg::ST_UF_FIND;
            end
            msl_pkg::ST_UF_FIND:
            begin
                // parent links are registered reads, so each step waits for its read
                if (sts.roots_found)
                    state_next = msl_pkg::ST_UF_EMIT;
                else
                begin
                    cmd.uf_step = 1'b1;
                    state_next  = msl_pkg::ST_UF_WAIT;
                end
            end
            msl_pkg::ST_UF_EMIT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.uf_emit = 1'b1;
                    if (sts.run_last)
                        state_next = msl_pkg::ST_LOAD;
                    else
                        state_next = msl_pkg::ST_UF_RD;
                end
            end
            default:
                state_next = msl_pkg::ST_LOAD;
        endcase
    end

endmodule

FILE: design/msl_dp.sv
// Datapath of the clustering block: distance memory, reach minima, edge list,
// parent links and output register. Depends on msl_pkg.
module msl_dp
#(
    parameter int MAX_POINTS = 64
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr,
    input  logic [msl_pkg::IdW-1:0]      cfg_data,
    input  logic [msl_pkg::DistW-1:0]    distance,
    input  msl_pkg::msl_cmd_t            cmd,
    output msl_pkg::msl_sts_t            sts,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [msl_pkg::IdW-1:0]      first_cluster,
    output logic [msl_pkg::IdW-1:0]      second_cluster,
    output logic [msl_pkg::DistW-1:0]    merge_distance,
    output logic                         last_merge
);

    localparam int StoreDepth = MAX_POINTS * (MAX_POINTS - 1) / 2;
    localparam int NodeDepth  = 2 * MAX_POINTS - 1;
    localparam int AW         = $clog2(StoreDepth + 1);
    localparam int PW         = $clog2(MAX_POINTS + 1);
    localparam int EW         = $clog2(MAX_POINTS);
    localparam int NW         = $clog2(NodeDepth + 1);
    localparam int DW         = msl_pkg::DistW;
    localparam int IW         = msl_pkg::IdW;
    localparam int LW         = DW + 2 * EW;   // edge entry {distance, a, b}

    // point count and pair total, clamped and computed on write
    logic [PW-1:0] npts_reg;
    logic [AW-1:0] total_reg;
    logic [IW-1:0] cfg_lo;
    always_comb
    begin
        cfg_lo = cfg_data;
        if (cfg_lo < IW'(2))
            cfg_lo = IW'(2);
        if (32'(cfg_lo) > MAX_POINTS)
            cfg_lo = IW'(MAX_POINTS);
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            npts_reg  <= PW'(MAX_POINTS);
            total_reg <= AW'(StoreDepth);
        end
        else if (cfg_wr)
        begin
            npts_reg  <= PW'(cfg_lo);
            total_reg <= AW'((32'(cfg_lo) * (32'(cfg_lo) - 32'd1)) >> 1);
        end
    end

    // load counter
    logic [AW-1:0] load_cnt_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            load_cnt_reg <= '0;
        else if (cfg_wr || cmd.load_clr)
            load_cnt_reg <= '0;
        else if (cmd.load_wr)
            load_cnt_reg <= load_cnt_reg + AW'(1);
    end
    assign sts.load_done = (load_cnt_reg + AW'(1) >= total_reg);

    // Prim state
    logic [MAX_POINTS-1:0] in_tree_reg;
    logic [EW-1:0]         x_reg, y_reg, j_reg;
    logic [PW-1:0]         i_reg;
    logic [DW-1:0]         minv_reg;
    logic                  have_reg;
    logic [AW-1:0]         row_base_reg;   // n*lo - lo*(lo+1)/2 for lo = x
    logic [NW-1:0]         sweep_reg;
    logic [AW-1:0]         base_acc_reg;
    logic [EW-1:0]         i_idx;
    assign i_idx = i_reg[EW-1:0];

    // sort and union-find state
    logic [LW-1:0] e_reg;
    logic [LW-1:0] prev_reg;
    logic [PW-1:0] k_reg;
    logic [NW-1:0] ra_reg, rb_reg;
    logic [DW-1:0] ud_reg;

    // slot of pair (x, j): row base of the smaller index plus offset
    logic [AW-1:0] slot_x_lt, slot_j_lt, base_j_reg;
    assign slot_x_lt = row_base_reg + AW'(j_reg) - AW'(x_reg) - AW'(1);
    assign slot_j_lt = base_j_reg + AW'(x_reg) - AW'(j_reg) - AW'(1);

    // running row base of j (base(j+1) = base(j) + n - j - 1)
    logic [AW-1:0] base_next;
    assign base_next = base_j_reg + AW'(npts_reg) - AW'(j_reg) - AW'(1);

    logic [AW-1:0] rd_addr;
    assign rd_addr = (x_reg < j_reg) ? slot_x_lt : slot_j_lt;

    // distance memory
    logic [DW-1:0] dmem [StoreDepth];
    logic [DW-1:0] dmem_q;
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
            dmem[load_cnt_reg] <= distance;
        dmem_q <= dmem[rd_addr];
    end

    // reach minima, read through a register ahead of the update
    logic [DW-1:0] reach_mem [MAX_POINTS];
    logic [DW-1:0] reach_q;
    logic [DW-1:0] cur_reach;
    assign cur_reach = (reach_q > dmem_q) ? dmem_q : reach_q;
    always_ff @(posedge clk)
    begin
        if (cmd.init_clr && 32'(sweep_reg) < MAX_POINTS)
            reach_mem[sweep_reg[EW-1:0]] <= '1;
        else if (cmd.prim_upd)
            reach_mem[j_reg] <= cur_reach;
        reach_q <= reach_mem[j_reg];
    end

    // row base of every point, filled during the clear sweep
    logic [AW-1:0] base_tab [MAX_POINTS];
    always_ff @(posedge clk)
    begin
        if (cmd.init_clr && 32'(sweep_reg) < MAX_POINTS)
            base_tab[sweep_reg[EW-1:0]] <= base_acc_reg;
    end

    // edge list, sorted in place
    logic [LW-1:0] edge_list [MAX_POINTS];
    always_ff @(posedge clk)
    begin
        if (cmd.prim_end)
            edge_list[i_idx] <= {minv_reg, x_reg, y_reg};
        else if (cmd.sort_shift)
            edge_list[k_reg[EW-1:0]] <= prev_reg;
        else if (cmd.sort_place)
            edge_list[k_reg[EW-1:0]] <= e_reg;
    end

    logic [NW-1:0] made;
    assign made = NW'(npts_reg) + NW'(i_reg);

    // parent links, read every cycle at both walk positions
    logic [NW-1:0] parent [NodeDepth];
    logic [NW-1:0] pa_q, pb_q;
    logic          ra_done, rb_done;
    always_ff @(posedge clk)
    begin
        if (cmd.init_clr)
            parent[sweep_reg] <= sweep_reg;
        else if (cmd.uf_emit && 32'(made) < NodeDepth)
        begin
            parent[ra_reg] <= made;
            parent[rb_reg] <= made;
        end
        pa_q <= parent[ra_reg];
        pb_q <= parent[rb_reg];
    end
    assign ra_done = (pa_q == ra_reg);
    assign rb_done = (pb_q == rb_reg);

    logic [NW-1:0] lo_r, hi_r;
    assign lo_r = (ra_reg < rb_reg) ? ra_reg : rb_reg;
    assign hi_r = (ra_reg < rb_reg) ? rb_reg : ra_reg;

    // main sequential datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_tree_reg    <= '0;
            sweep_reg      <= '0;
            base_acc_reg   <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            x_reg          <= '0;
            y_reg          <= '0;
            minv_reg       <= '1;
            have_reg       <= 1'b0;
            row_base_reg   <= '0;
            base_j_reg     <= '0;
            e_reg          <= '0;
            prev_reg       <= '0;
            k_reg          <= '0;
            ra_reg         <= '0;
            rb_reg         <= '0;
            ud_reg         <= '0;
            out_valid      <= 1'b0;
            first_cluster  <= '0;
            second_cluster <= '0;
            merge_distance <= '0;
            last_merge     <= 1'b0;
        end
        else
        begin
            // clear sweep: one parent entry and one point per cycle
            if (cmd.init_clr)
            begin
                if (32'(sweep_reg) < MAX_POINTS)
                begin
                    in_tree_reg[sweep_reg[EW-1:0]] <= 1'b0;
                    base_acc_reg <= base_acc_reg + AW'(npts_reg)
                                    - AW'(sweep_reg) - AW'(1);
                end
                sweep_reg <= sweep_reg + NW'(1);
                x_reg     <= '0;
                row_base_reg <= '0;
            end
            else
            begin
                sweep_reg    <= '0;
                base_acc_reg <= '0;
            end

            if (cmd.run_start)
                i_reg <= '0;

            if (cmd.prim_start)
            begin
                in_tree_reg[x_reg] <= 1'b1;
                have_reg   <= 1'b0;
                minv_reg   <= '1;
                j_reg      <= '0;
                base_j_reg <= '0;
            end

            if (cmd.prim_upd)
            begin
                if (!have_reg || cur_reach < minv_reg)
                begin
                    have_reg <= 1'b1;
                    minv_reg <= cur_reach;
                    y_reg    <= j_reg;
                end
            end

            if (cmd.prim_next_j)
            begin
                j_reg      <= j_reg + EW'(1);
                base_j_reg <= base_next;
            end

            if (cmd.prim_end)
            begin
                x_reg        <= y_reg;
                row_base_reg <= base_tab[y_reg];
                if (sts.i_last_prim)
                    i_reg <= PW'(1);
                else
                    i_reg <= i_reg + PW'(1);
            end

            // insertion sort
            if (cmd.sort_start)
            begin
                e_reg <= edge_list[i_idx];
                k_reg <= i_reg;
            end
            if (cmd.sort_rd)
                prev_reg <= edge_list[k_reg[EW-1:0] - EW'(1)];
            if (cmd.sort_shift)
                k_reg <= k_reg - PW'(1);
            if (cmd.sort_place)
                i_reg <= i_reg + PW'(1);

            // union-find
            if (cmd.uf_rd)
            begin
                ra_reg <= NW'(edge_list[i_idx][2*EW-1:EW]);
                rb_reg <= NW'(edge_list[i_idx][EW-1:0]);
                ud_reg <= edge_list[i_idx][LW-1:2*EW];
            end
            if (cmd.uf_step)
            begin
                if (!ra_done)
                    ra_reg <= pa_q;
                if (!rb_done)
                    rb_reg <= pb_q;
            end

            // result register
            if (cmd.uf_emit)
            begin
                first_cluster  <= IW'(lo_r);
                second_cluster <= IW'(hi_r);
                merge_distance <= ud_reg;
                last_merge     <= sts.run_last;
                out_valid      <= 1'b1;
                i_reg          <= i_reg + PW'(1);
            end
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

    // status
    assign sts.init_done   = (32'(sweep_reg) == NodeDepth - 1);
    assign sts.j_in_tree   = in_tree_reg[j_reg];
    assign sts.j_last      = (PW'(j_reg) == npts_reg - PW'(1));
    assign sts.i_last_prim = (i_reg + PW'(2) == npts_reg);
    assign sts.sort_done   = (i_reg + PW'(1) >= npts_reg);
    assign sts.k_zero      = (k_reg == '0);
    assign sts.sort_move   = (prev_reg[LW-1:2*EW] > e_reg[LW-1:2*EW]);
    assign sts.roots_found = ra_done && rb_done;
    assign sts.out_busy    = out_valid && !out_ready;
    assign sts.run_last    = (i_reg + PW'(2) == npts_reg);

endmodule

FILE: design/mst_single_linkage_top.sv
// channel   | handshake                 | payload
// cfg       | cfg_valid / cfg_ready     | point_count (7 bits)
// in        | in_valid / in_ready       | distance (32 bits)
// out       | out_valid / out_ready     | first_cluster, second_cluster, merge_distance, last_merge
//
// Loading takes one distance per cycle; in_ready is low while cfg_valid is high.
// After the last distance, a clear sweep runs, then Prim's tree is built (read,
// wait, update per candidate), the insertion sort runs, and each merge reads its
// edge, walks both roots up the parent links with a read and a wait per step and
// emits. No input or config is taken meanwhile. Reset puts point_count at
// MAX_POINTS and empties the load. Output stalls hold the emitter until the
// result register is free.
// Top level: joins msl_ctrl and msl_dp; depends on msl_pkg.
module mst_single_linkage_top
#(
    parameter int MAX_POINTS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  point_count,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] distance,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [6:0]  first_cluster,
    output logic [6:0]  second_cluster,
    output logic [31:0] merge_distance,
    output logic        last_merge
);

    msl_pkg::msl_cmd_t cmd;
    msl_pkg::msl_sts_t sts;
    logic              busy;
    logic              ctrl_in_ready;

    assign cfg_ready = !busy;
    // a pending config write takes precedence over input
    assign in_ready  = ctrl_in_ready && !cfg_valid;

    msl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid && !cfg_valid),
        .in_ready (ctrl_in_ready),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy)
    );

    msl_dp #(.MAX_POINTS(MAX_POINTS)) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr         (cfg_valid && cfg_ready),
        .cfg_data       (point_count),
        .distance       (distance),
        .cmd            (cmd),
        .sts            (sts),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .first_cluster  (first_cluster),
        .second_cluster (second_cluster),
        .merge_distance (merge_distance),
        .last_merge     (last_merge)
    );

endmodule
